// ===== hdl/modbus_rtu_master_engine_assert.svh =====
// Assertion macros for the Modbus RTU master engine.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef MODBUS_RTU_MASTER_ENGINE_ASSERT_SVH
`define MODBUS_RTU_MASTER_ENGINE_ASSERT_SVH
// same-cycle implication
`define MRM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define MRM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/mrm_pkg.sv =====
// Package for the Modbus RTU master engine: codes, limits, CRC step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrm_pkg;
    localparam int HOLD_REGS   = 64;
    localparam int INPUT_REGS  = 64;
    localparam int COILS       = 512;
    localparam int DISC_INPUTS = 512;
    localparam int RX_LEN      = 256;
    localparam int MAX_PAYLOAD = 246;
    localparam int STORE_DEPTH = 64;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_PAY   = 3'd1;
    localparam logic [2:0] CMD_RXB   = 3'd2;
    localparam logic [2:0] CMD_TOUT  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_STAT = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_SIZE  = 3'd1;
    localparam logic [2:0] ST_NORSP = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_SLAVE = 3'd4;
    localparam logic [2:0] ST_ECHO  = 3'd5;

    localparam logic [4:0] FN_RD_COIL = 5'd1;
    localparam logic [4:0] FN_RD_DISC = 5'd2;
    localparam logic [4:0] FN_RD_HOLD = 5'd3;
    localparam logic [4:0] FN_RD_INP  = 5'd4;
    localparam logic [4:0] FN_WR_COIL = 5'd5;
    localparam logic [4:0] FN_WR_REG  = 5'd6;
    localparam logic [4:0] FN_WR_COILS = 5'd15;
    localparam logic [4:0] FN_WR_REGS = 5'd16;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_PAY  = 2'd1;
    localparam logic [1:0] PH_RX   = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/modbus_rtu_master_engine.sv =====
// Modbus RTU master engine top level: frame builder, response checker, stores.
// Depends on mrm_pkg and modbus_rtu_master_engine_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_master_engine_assert.svh"

// One request at a time. A start request emits its frame bytes one per cycle
// while the output is free (7 or 8 bytes), a payload request 1 to 4 bytes;
// a received byte is buffered, the final one then passes a check state plus a
// copy walk of the response buffer (one buffer read per cycle, up to 128 bytes)
// into the store memory on a good read; a store read passes through the
// registered memory read. Results leave through an output register, so the next
// request is taken while a result still waits. Stores read as zero until written.
module modbus_rtu_master_engine
    import mrm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  command,
    input  wire logic [4:0]  function_code,
    input  wire logic [7:0]  slave_address,
    input  wire logic [15:0] start_address,
    input  wire logic [15:0] quantity,
    input  wire logic [15:0] write_value,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [1:0]  store_select,
    input  wire logic [5:0]  store_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_kind,
    output logic [7:0]       tx_byte,
    output logic             last,
    output logic [2:0]       status,
    output logic [15:0]      read_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TX    = 3'd1;
    localparam logic [2:0] S_STAT  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_JUDGE = 3'd4;
    localparam logic [2:0] S_COPY  = 3'd5;

    logic [2:0]  state_reg;
    logic [1:0]  phase_reg;
    logic [7:0]  slave_reg;
    logic [4:0]  func_reg;
    logic [8:0]  exp_len_reg;
    logic [8:0]  cnt_reg;
    logic [15:0] crc_reg;
    logic [15:0] echo_reg;
    logic [7:0]  tx_buf_reg [8];
    logic [3:0]  n_data_reg;
    logic        add_crc_reg;
    logic        rx_after_reg;
    logic [3:0]  tx_idx_reg;
    logic [7:0]  b0_reg, b2_reg, b4_reg, b5_reg, prev_reg, lastb_reg;
    logic [2:0]  stat_reg;
    logic [7:0]  copy_n_reg, copy_k_reg, copy_kd_reg, copy_hi_reg;
    logic        copy_vld_reg;

    logic        out_valid_reg, last_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  txb_reg;
    logic [2:0]  status_reg;
    logic [15:0] rdata_reg;

    // memories
    logic [7:0]  rx_mem [256];
    logic [7:0]  rx_q_reg;
    logic [15:0] st_mem [256];
    logic [15:0] st_q_reg;
    logic [255:0] st_vld_reg;
    logic        st_qv_reg;

    logic        accept, slot, out_load;
    logic        rx_we, st_we, st_re;
    logic [7:0]  rx_raddr, st_waddr, st_raddr;
    logic [15:0] st_wdata;

    // start decode
    logic [16:0] q7;
    logic [13:0] ceil8;
    logic [17:0] rd_len, bc, lim;
    logic        st_known, st_read, st_multi, st_over;
    logic [7:0]  sb4, sb5;

    // payload decode
    logic [8:0]  pay_cnt;

    // tx sequencing
    logic [3:0]  tx_end;
    logic [7:0]  tx_cur;

    // judge
    logic        j_read;
    logic [2:0]  j_stat;
    logic [7:0]  j_elems, j_nbytes;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign slot     = !out_valid_reg || out_ready;
    assign out_load = slot && ((state_reg == S_TX) || (state_reg == S_STAT)
                               || (state_reg == S_RD));

    always_comb
    begin
        q7    = {1'b0, quantity} + 17'd7;
        ceil8 = q7[16:3];
        st_read  = (function_code >= FN_RD_COIL) && (function_code <= FN_RD_INP);
        st_multi = (function_code == FN_WR_COILS) || (function_code == FN_WR_REGS);
        st_known = st_read || st_multi || (function_code == FN_WR_COIL)
                   || (function_code == FN_WR_REG);
        unique case (function_code)
            FN_RD_COIL: lim = 18'(COILS);
            FN_RD_DISC: lim = 18'(DISC_INPUTS);
            FN_RD_HOLD: lim = 18'(HOLD_REGS);
            default:    lim = 18'(INPUT_REGS);
        endcase
        if (function_code <= FN_RD_DISC)
            rd_len = {4'b0, ceil8} + 18'd5;
        else
            rd_len = {1'b0, quantity, 1'b0} + 18'd5;
        if (function_code == FN_WR_COILS)
            bc = {4'b0, ceil8};
        else
            bc = {1'b0, quantity, 1'b0};
        if (st_read)
            st_over = ({2'b0, quantity} > lim) || (rd_len > 18'(RX_LEN));
        else if (st_multi)
            st_over = (bc == 18'd0) || (bc > 18'(MAX_PAYLOAD));
        else
            st_over = 1'b0;
        if (function_code == FN_WR_COIL)
        begin
            sb4 = (write_value[7:0] != 8'h00) ? 8'hFF : 8'h00;
            sb5 = 8'h00;
        end
        else if (function_code == FN_WR_REG)
        begin
            sb4 = write_value[15:8];
            sb5 = write_value[7:0];
        end
        else
        begin
            sb4 = quantity[15:8];
            sb5 = quantity[7:0];
        end
    end

    always_comb
    begin
        if (func_reg == FN_WR_COILS)
            pay_cnt = cnt_reg - 9'd1;
        else
            pay_cnt = (cnt_reg >= 9'd2) ? cnt_reg - 9'd2 : 9'd0;
    end

    always_comb
    begin
        tx_end = add_crc_reg ? n_data_reg + 4'd1 : n_data_reg - 4'd1;
        if (tx_idx_reg < n_data_reg)
            tx_cur = tx_buf_reg[tx_idx_reg[2:0]];
        else if (tx_idx_reg == n_data_reg)
            tx_cur = crc_reg[7:0];
        else
            tx_cur = crc_reg[15:8];
    end

    always_comb
    begin
        j_read = (func_reg <= FN_RD_INP);
        if (exp_len_reg < 9'd5)
            j_stat = ST_CRC;
        else if (j_read && ({1'b0, b2_reg} != exp_len_reg - 9'd5))
            j_stat = ST_CRC;
        else if ((prev_reg != crc_reg[7:0]) || (lastb_reg != crc_reg[15:8]))
            j_stat = ST_CRC;
        else if (b0_reg != slave_reg)
            j_stat = ST_SLAVE;
        else if (!j_read && ({b4_reg, b5_reg} != echo_reg))
            j_stat = ST_ECHO;
        else
            j_stat = ST_OK;
        if (func_reg <= FN_RD_DISC)
        begin
            j_elems  = (b2_reg > 8'(STORE_DEPTH)) ? 8'(STORE_DEPTH) : b2_reg;
            j_nbytes = j_elems;
        end
        else
        begin
            j_elems  = ({1'b0, b2_reg[7:1]} > 8'(STORE_DEPTH)) ? 8'(STORE_DEPTH)
                       : {1'b0, b2_reg[7:1]};
            j_nbytes = {j_elems[6:0], 1'b0};
        end
    end

    // memory port control
    always_comb
    begin
        rx_we    = accept && (command == CMD_RXB) && (phase_reg == PH_RX)
                   && (cnt_reg < exp_len_reg);
        rx_raddr = 8'd3 + copy_k_reg;
        st_re    = accept && (command == CMD_READ);
        st_raddr = {store_select, store_index};
        st_we    = (state_reg == S_COPY) && copy_vld_reg
                   && ((func_reg <= FN_RD_DISC) || copy_kd_reg[0]);
        if (func_reg <= FN_RD_DISC)
        begin
            st_waddr = {func_reg[1:0] - 2'd1, copy_kd_reg[5:0]};
            st_wdata = {8'h00, rx_q_reg};
        end
        else
        begin
            st_waddr = {func_reg[1:0] - 2'd1, copy_kd_reg[6:1]};
            st_wdata = {copy_hi_reg, rx_q_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_we)
            rx_mem[cnt_reg[7:0]] <= rx_byte;
        rx_q_reg <= rx_mem[rx_raddr];
        if (st_we)
            st_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_q_reg <= st_mem[st_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_vld_reg <= '0;
            st_qv_reg  <= 1'b0;
        end
        else
        begin
            if (st_we)
                st_vld_reg[st_waddr] <= 1'b1;
            if (st_re)
                st_qv_reg <= st_vld_reg[st_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_IDLE;
            slave_reg     <= '0;
            func_reg      <= '0;
            exp_len_reg   <= '0;
            cnt_reg       <= '0;
            crc_reg       <= CRC_INIT;
            echo_reg      <= '0;
            tx_buf_reg    <= '{default: '0};
            n_data_reg    <= '0;
            add_crc_reg   <= 1'b0;
            rx_after_reg  <= 1'b0;
            tx_idx_reg    <= '0;
            b0_reg        <= '0;
            b2_reg        <= '0;
            b4_reg        <= '0;
            b5_reg        <= '0;
            prev_reg      <= '0;
            lastb_reg     <= '0;
            stat_reg      <= ST_OK;
            copy_n_reg    <= '0;
            copy_kd_reg   <= '0;
            copy_hi_reg   <= '0;
            copy_vld_reg  <= 1'b0;
            copy_k_reg    <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            kind_reg      <= KIND_TX;
            txb_reg       <= '0;
            status_reg    <= ST_OK;
            rdata_reg     <= '0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (command)
                            CMD_START:
                            begin
                                if (st_known && st_over)
                                begin
                                    phase_reg <= PH_IDLE;
                                    stat_reg  <= ST_SIZE;
                                    state_reg <= S_STAT;
                                end
                                else if (st_known)
                                begin
                                    slave_reg     <= slave_address;
                                    func_reg      <= function_code;
                                    echo_reg      <= {sb4, sb5};
                                    crc_reg       <= CRC_INIT;
                                    tx_buf_reg[0] <= slave_address;
                                    tx_buf_reg[1] <= {3'b000, function_code};
                                    tx_buf_reg[2] <= start_address[15:8];
                                    tx_buf_reg[3] <= start_address[7:0];
                                    tx_buf_reg[4] <= sb4;
                                    tx_buf_reg[5] <= sb5;
                                    tx_buf_reg[6] <= bc[7:0];
                                    tx_idx_reg    <= '0;
                                    state_reg     <= S_TX;
                                    if (st_multi)
                                    begin
                                        n_data_reg   <= 4'd7;
                                        add_crc_reg  <= 1'b0;
                                        rx_after_reg <= 1'b0;
                                        cnt_reg      <= bc[8:0];
                                        phase_reg    <= PH_PAY;
                                    end
                                    else
                                    begin
                                        n_data_reg   <= 4'd6;
                                        add_crc_reg  <= 1'b1;
                                        rx_after_reg <= 1'b1;
                                        cnt_reg      <= '0;
                                        exp_len_reg  <= st_read ? rd_len[8:0] : 9'd8;
                                        phase_reg    <= PH_RX;
                                    end
                                end
                            end
                            CMD_PAY:
                            begin
                                if (phase_reg == PH_PAY)
                                begin
                                    if (func_reg == FN_WR_COILS)
                                    begin
                                        tx_buf_reg[0] <= write_value[7:0];
                                        n_data_reg    <= 4'd1;
                                    end
                                    else
                                    begin
                                        tx_buf_reg[0] <= write_value[15:8];
                                        tx_buf_reg[1] <= write_value[7:0];
                                        n_data_reg    <= 4'd2;
                                    end
                                    add_crc_reg  <= (pay_cnt == 9'd0);
                                    rx_after_reg <= (pay_cnt == 9'd0);
                                    tx_idx_reg   <= '0;
                                    state_reg    <= S_TX;
                                    if (pay_cnt == 9'd0)
                                    begin
                                        phase_reg   <= PH_RX;
                                        exp_len_reg <= 9'd8;
                                        cnt_reg     <= '0;
                                    end
                                    else
                                        cnt_reg <= pay_cnt;
                                end
                            end
                            CMD_RXB:
                            begin
                                if (rx_we)
                                begin
                                    if (cnt_reg + 9'd2 < exp_len_reg)
                                        crc_reg <= crc_byte(crc_reg, rx_byte);
                                    if (cnt_reg == 9'd0)
                                        b0_reg <= rx_byte;
                                    if (cnt_reg == 9'd2)
                                        b2_reg <= rx_byte;
                                    if (cnt_reg == 9'd4)
                                        b4_reg <= rx_byte;
                                    if (cnt_reg == 9'd5)
                                        b5_reg <= rx_byte;
                                    prev_reg  <= lastb_reg;
                                    lastb_reg <= rx_byte;
                                    cnt_reg   <= cnt_reg + 9'd1;
                                    if (cnt_reg + 9'd1 >= exp_len_reg)
                                    begin
                                        phase_reg <= PH_IDLE;
                                        state_reg <= S_JUDGE;
                                    end
                                end
                            end
                            CMD_TOUT:
                            begin
                                if (phase_reg != PH_IDLE)
                                begin
                                    phase_reg <= PH_IDLE;
                                    stat_reg  <= ST_NORSP;
                                    state_reg <= S_STAT;
                                end
                            end
                            CMD_READ:
                                state_reg <= S_RD;
                            default:
                                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_TX:
                begin
                    if (slot)
                    begin
                        kind_reg      <= KIND_TX;
                        txb_reg       <= tx_cur;
                        status_reg    <= ST_OK;
                        rdata_reg     <= '0;
                        last_reg      <= (tx_idx_reg == tx_end);
                        if (tx_idx_reg < n_data_reg)
                            crc_reg <= crc_byte(crc_reg, tx_cur);
                        tx_idx_reg <= tx_idx_reg + 4'd1;
                        if (tx_idx_reg == tx_end)
                        begin
                            // open the receive window with a fresh CRC
                            if (rx_after_reg)
                                crc_reg <= CRC_INIT;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_JUDGE:
                begin
                    stat_reg     <= j_stat;
                    copy_n_reg   <= j_nbytes;
                    copy_k_reg   <= '0;
                    copy_vld_reg <= 1'b0;
                    state_reg    <= (j_read && (j_stat == ST_OK)) ? S_COPY : S_STAT;
                end
                S_COPY:
                begin
                    if (copy_k_reg < copy_n_reg)
                    begin
                        copy_vld_reg <= 1'b1;
                        copy_kd_reg  <= copy_k_reg;
                        copy_k_reg   <= copy_k_reg + 8'd1;
                    end
                    else
                        copy_vld_reg <= 1'b0;
                    // hold the high byte of each register word
                    if (copy_vld_reg && !copy_kd_reg[0])
                        copy_hi_reg <= rx_q_reg;
                    if ((copy_k_reg == copy_n_reg) && !copy_vld_reg)
                        state_reg <= S_STAT;
                end
                S_STAT:
                begin
                    if (slot)
                    begin
                        kind_reg      <= KIND_STAT;
                        txb_reg       <= '0;
                        status_reg    <= stat_reg;
                        rdata_reg     <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_RD:
                begin
                    if (slot)
                    begin
                        kind_reg      <= KIND_DATA;
                        txb_reg       <= '0;
                        status_reg    <= ST_OK;
                        rdata_reg     <= st_qv_reg ? st_q_reg : 16'h0000;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign tx_byte     = txb_reg;
    assign last        = last_reg;
    assign status      = status_reg;
    assign read_data   = rdata_reg;

    `MRM_ASSERT_NOW(a_stat_last, out_valid_reg && (kind_reg != KIND_TX), last_reg)
    `MRM_ASSERT_NOW(a_tx_idx, state_reg == S_TX, tx_idx_reg <= tx_end)
    `MRM_ASSERT_NOW(a_copy_idle, state_reg == S_COPY, phase_reg == PH_IDLE)
    `MRM_ASSERT_NEXT(a_judge_next, state_reg == S_JUDGE,
        (state_reg == S_COPY) || (state_reg == S_STAT))
endmodule
`default_nettype wire

// ===== tb/modbus_rtu_master_engine_test.sv =====
// Self-checking testbench for the Modbus RTU master engine.
// It builds request frames, slave responses and store reads, and checks every result
// against an in-bench model of the engine. Depends on mrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_master_engine_test;
    import mrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int RANDOM_ITEMS   = 360;
    localparam int DIR_ROWS       = 20;

    typedef struct {
        logic [2:0]  cmd;
        logic [4:0]  fn;
        logic [7:0]  slave;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [15:0] wval;
        logic [7:0]  rxb;
        logic [1:0]  sel;
        logic [5:0]  idx;
    } request_t;

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  txb;
        logic        lst;
        logic [2:0]  st;
        logic [15:0] data;
    } outcome_t;

    typedef struct {
        request_t req;
        bit       typed;
        outcome_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [4:0]  function_code;
    logic [7:0]  slave_address;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic [15:0] write_value;
    logic [7:0]  rx_byte;
    logic [1:0]  store_select;
    logic [5:0]  store_index;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [2:0]  status;
    logic [15:0] read_data;

    modbus_rtu_master_engine dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .function_code(function_code),
        .slave_address(slave_address), .start_address(start_address),
        .quantity(quantity), .write_value(write_value), .rx_byte(rx_byte),
        .store_select(store_select), .store_index(store_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_kind(result_kind), .tx_byte(tx_byte), .last(last),
        .status(status), .read_data(read_data)
    );

    // Engine model state
    logic [7:0]  coil_mem [0:STORE_DEPTH-1];
    logic [7:0]  disc_mem [0:STORE_DEPTH-1];
    logic [15:0] hold_mem [0:STORE_DEPTH-1];
    logic [15:0] inp_mem  [0:STORE_DEPTH-1];
    logic [7:0]  resp_buf [0:255];
    logic [7:0]  cur_slave;
    logic [7:0]  cur_func;
    logic [15:0] cur_qty;
    logic [15:0] resp_len;
    logic [15:0] byte_cnt;
    logic [15:0] crc_run;
    logic [15:0] echo_word;
    logic [1:0]  eng_phase;

    outcome_t step_out [0:7];
    int       step_n;
    outcome_t expected_results [$];

    dir_row_t dir_table [0:DIR_ROWS-1];
    int  err_count;
    int  idle_cycles;
    int  sent_count;
    int  send_idle_pct;
    int  recv_stall_pct;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [15:0] frame_crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ 16'hA001;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    task automatic emit(input logic [1:0] kind, input logic [7:0] txb,
                        input logic [2:0] st, input logic [15:0] data);
        step_out[step_n] = '{kind: kind, txb: txb, lst: 1'b0, st: st, data: data};
        step_n++;
    endtask

    task automatic emit_tx(input logic [7:0] b);
        crc_run = frame_crc_step(crc_run, b);
        emit(KIND_TX, b, ST_OK, 16'h0);
    endtask

    task automatic emit_crc();
        logic [15:0] c;
        c = crc_run;
        emit(KIND_TX, c[7:0], ST_OK, 16'h0);
        emit(KIND_TX, c[15:8], ST_OK, 16'h0);
    endtask

    task automatic open_receive(input logic [15:0] len);
        resp_len = len;
        byte_cnt = 16'h0;
        crc_run = 16'hFFFF;
        eng_phase = PH_RX;
    endtask

    function automatic logic [2:0] judge_response();
        int len;
        int cnt;
        logic [15:0] w;
        len = int'(resp_len);
        if (len < 5 || len > 256)
            return ST_CRC;
        if (cur_func <= 4 && int'(resp_buf[2]) != len - 5)
            return ST_CRC;
        if (resp_buf[len-2] != crc_run[7:0] || resp_buf[len-1] != crc_run[15:8])
            return ST_CRC;
        if (resp_buf[0] != cur_slave)
            return ST_SLAVE;
        if (cur_func > 4)
            return ({resp_buf[4], resp_buf[5]} != echo_word) ? ST_ECHO : ST_OK;
        cnt = int'(resp_buf[2]);
        // copy into the store, dropping anything past its depth
        for (int i = 0; i < cnt && i < STORE_DEPTH; i++)
        begin
            if (cur_func == FN_RD_COIL)
                coil_mem[i] = resp_buf[3+i];
            else if (cur_func == FN_RD_DISC)
                disc_mem[i] = resp_buf[3+i];
        end
        for (int i = 0; i < cnt / 2 && i < STORE_DEPTH; i++)
        begin
            w = {resp_buf[3+2*i], resp_buf[4+2*i]};
            if (cur_func == FN_RD_HOLD)
                hold_mem[i] = w;
            else if (cur_func == FN_RD_INP)
                inp_mem[i] = w;
        end
        return ST_OK;
    endfunction

    task automatic start_frame(input request_t r);
        int lim;
        int len;
        int bc;
        logic [7:0] b4;
        logic [7:0] b5;
        int q;
        lim = 0;
        len = 0;
        bc = 0;
        b4 = 8'h0;
        b5 = 8'h0;
        q = int'(r.qty);
        if (r.fn >= FN_RD_COIL && r.fn <= FN_RD_INP)
        begin
            lim = (r.fn == FN_RD_COIL) ? COILS : (r.fn == FN_RD_DISC) ? DISC_INPUTS
                : (r.fn == FN_RD_HOLD) ? HOLD_REGS : INPUT_REGS;
            len = (r.fn <= FN_RD_DISC) ? (q + 7) / 8 + 5 : 2 * q + 5;
            if (q > lim || len > RX_LEN)
            begin
                eng_phase = PH_IDLE;
                emit(KIND_STAT, 8'h0, ST_SIZE, 16'h0);
                return;
            end
            b4 = r.qty[15:8];
            b5 = r.qty[7:0];
        end
        else if (r.fn == FN_WR_COIL)
        begin
            b4 = (r.wval[7:0] != 8'h0) ? 8'hFF : 8'h00;
        end
        else if (r.fn == FN_WR_REG)
        begin
            b4 = r.wval[15:8];
            b5 = r.wval[7:0];
        end
        else if (r.fn == FN_WR_COILS || r.fn == FN_WR_REGS)
        begin
            bc = (r.fn == FN_WR_COILS) ? (q + 7) / 8 : 2 * q;
            if (bc == 0 || bc > MAX_PAYLOAD)
            begin
                eng_phase = PH_IDLE;
                emit(KIND_STAT, 8'h0, ST_SIZE, 16'h0);
                return;
            end
            b4 = r.qty[15:8];
            b5 = r.qty[7:0];
        end
        else
        begin
            return;
        end
        cur_slave = r.slave;
        cur_func = {3'b000, r.fn};
        cur_qty = r.qty;
        echo_word = {b4, b5};
        crc_run = 16'hFFFF;
        emit_tx(r.slave);
        emit_tx({3'b000, r.fn});
        emit_tx(r.addr[15:8]);
        emit_tx(r.addr[7:0]);
        emit_tx(b4);
        emit_tx(b5);
        if (r.fn == FN_WR_COILS || r.fn == FN_WR_REGS)
        begin
            emit_tx(bc[7:0]);
            byte_cnt = bc[15:0];
            eng_phase = PH_PAY;
            return;
        end
        emit_crc();
        open_receive((r.fn <= FN_RD_INP) ? len[15:0] : 16'd8);
    endtask

    task automatic predict_results(input request_t r);
        logic [15:0] d;
        step_n = 0;
        case (r.cmd)
            CMD_START: start_frame(r);
            CMD_PAY:
            begin
                if (eng_phase == PH_PAY)
                begin
                    if (cur_func == FN_WR_COILS)
                    begin
                        emit_tx(r.wval[7:0]);
                        byte_cnt = byte_cnt - 16'd1;
                    end
                    else
                    begin
                        emit_tx(r.wval[15:8]);
                        emit_tx(r.wval[7:0]);
                        byte_cnt = (byte_cnt >= 2) ? byte_cnt - 16'd2 : 16'd0;
                    end
                    if (byte_cnt == 0)
                    begin
                        emit_crc();
                        open_receive(16'd8);
                    end
                end
            end
            CMD_RXB:
            begin
                if (eng_phase == PH_RX && byte_cnt < resp_len && byte_cnt < 256)
                begin
                    resp_buf[byte_cnt[7:0]] = r.rxb;
                    if (byte_cnt + 2 < resp_len)
                        crc_run = frame_crc_step(crc_run, r.rxb);
                    byte_cnt = byte_cnt + 16'd1;
                    if (byte_cnt >= resp_len)
                    begin
                        eng_phase = PH_IDLE;
                        emit(KIND_STAT, 8'h0, judge_response(), 16'h0);
                    end
                end
            end
            CMD_TOUT:
            begin
                if (eng_phase != PH_IDLE)
                begin
                    eng_phase = PH_IDLE;
                    emit(KIND_STAT, 8'h0, ST_NORSP, 16'h0);
                end
            end
            CMD_READ:
            begin
                case (r.sel)
                    2'd0: d = {8'h00, coil_mem[r.idx]};
                    2'd1: d = {8'h00, disc_mem[r.idx]};
                    2'd2: d = hold_mem[r.idx];
                    default: d = inp_mem[r.idx];
                endcase
                emit(KIND_DATA, 8'h0, ST_OK, d);
            end
            default: ;
        endcase
        if (step_n > 0)
            step_out[step_n-1].lst = 1'b1;
    endtask

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Drive one request and wait for it to be taken; then queue what it should cause.
    task automatic send_request(input request_t r, input bit typed, input outcome_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= r.cmd;
        function_code <= r.fn;
        slave_address <= r.slave;
        start_address <= r.addr;
        quantity      <= r.qty;
        write_value   <= r.wval;
        rx_byte       <= r.rxb;
        store_select  <= r.sel;
        store_index   <= r.idx;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sent_count++;
        predict_results(r);
        if (typed)
            expected_results.push_back(want);
        else
            for (int i = 0; i < step_n; i++)
                expected_results.push_back(step_out[i]);
    endtask

    function automatic request_t noise_request();
        request_t r;
        r.cmd   = 3'($urandom_range(0, 7));
        r.fn    = 5'($urandom);
        r.slave = 8'($urandom);
        r.addr  = 16'($urandom);
        r.qty   = 16'($urandom);
        r.wval  = 16'($urandom);
        r.rxb   = 8'($urandom);
        r.sel   = 2'($urandom);
        r.idx   = 6'($urandom);
        return r;
    endfunction

    task automatic send_plain(input request_t r);
        outcome_t none;
        none = '{kind: KIND_TX, txb: 8'h0, lst: 1'b0, st: ST_OK, data: 16'h0};
        send_request(r, 1'b0, none);
    endtask

    function automatic dir_row_t mk_row(input logic [2:0] cmd, input logic [4:0] fn,
                                        input logic [7:0] slave, input logic [15:0] addr,
                                        input logic [15:0] qty, input logic [15:0] wval,
                                        input logic [1:0] sel, input logic [5:0] idx,
                                        input bit typed, input logic [1:0] kind,
                                        input logic [2:0] st);
        dir_row_t row;
        row.req = '{cmd: cmd, fn: fn, slave: slave, addr: addr, qty: qty, wval: wval,
                    rxb: 8'hFF, sel: sel, idx: idx};
        row.typed = typed;
        row.want = '{kind: kind, txb: 8'h0, lst: 1'b1, st: st, data: 16'h0};
        return row;
    endfunction

    task automatic fill_dir_table();
        dir_table[0]  = mk_row(CMD_READ, 5'd0, 8'h0, 16'h0, 16'h0, 16'h0, 2'd0, 6'd0,
                               1'b1, KIND_DATA, ST_OK);
        dir_table[1]  = mk_row(CMD_READ, 5'd31, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               2'd3, 6'd63, 1'b1, KIND_DATA, ST_OK);
        dir_table[2]  = mk_row(CMD_TOUT, 5'd0, 8'h0, 16'h0, 16'h0, 16'h0, 2'd0, 6'd0,
                               1'b0, KIND_TX, ST_OK);
        dir_table[3]  = mk_row(CMD_START, FN_RD_HOLD, 8'h11, 16'h0, 16'd65, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_SIZE);
        dir_table[4]  = mk_row(CMD_START, FN_RD_COIL, 8'h11, 16'h0, 16'd513, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_SIZE);
        dir_table[5]  = mk_row(CMD_START, FN_RD_INP, 8'h22, 16'hFFFF, 16'hFFFF, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_SIZE);
        dir_table[6]  = mk_row(CMD_START, FN_WR_REGS, 8'h01, 16'h0, 16'd0, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_SIZE);
        dir_table[7]  = mk_row(CMD_START, FN_WR_COILS, 8'h01, 16'h0, 16'd1977, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_SIZE);
        dir_table[8]  = mk_row(CMD_START, 5'd7, 8'h01, 16'h0, 16'd1, 16'h0,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[9]  = mk_row(CMD_PAY, 5'd0, 8'h0, 16'h0, 16'h0, 16'hFFFF,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[10] = mk_row(CMD_RXB, 5'd0, 8'h0, 16'h0, 16'h0, 16'h0,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[11] = mk_row(3'd7, 5'd31, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               2'd3, 6'd63, 1'b0, KIND_TX, ST_OK);
        dir_table[12] = mk_row(CMD_START, FN_WR_REG, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[13] = mk_row(CMD_TOUT, 5'd0, 8'h0, 16'h0, 16'h0, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_NORSP);
        dir_table[14] = mk_row(CMD_START, FN_WR_COIL, 8'h00, 16'h0000, 16'h0, 16'h0100,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[15] = mk_row(CMD_START, FN_RD_INP, 8'h05, 16'h1234, 16'd0, 16'h0,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[16] = mk_row(CMD_TOUT, 5'd0, 8'h0, 16'h0, 16'h0, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_NORSP);
        dir_table[17] = mk_row(CMD_START, FN_RD_DISC, 8'h7F, 16'h8000, 16'd512, 16'h0,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[18] = mk_row(CMD_START, FN_WR_COIL, 8'h80, 16'h0001, 16'h0, 16'h00FF,
                               2'd0, 6'd0, 1'b0, KIND_TX, ST_OK);
        dir_table[19] = mk_row(CMD_TOUT, 5'd0, 8'h0, 16'h0, 16'h0, 16'h0,
                               2'd0, 6'd0, 1'b1, KIND_STAT, ST_NORSP);
    endtask

    function automatic logic [4:0] pick_function();
        int p;
        p = $urandom_range(0, 99);
        if (p < 12) return FN_RD_COIL;
        if (p < 22) return FN_RD_DISC;
        if (p < 36) return FN_RD_HOLD;
        if (p < 48) return FN_RD_INP;
        if (p < 60) return FN_WR_COIL;
        if (p < 72) return FN_WR_REG;
        if (p < 84) return FN_WR_COILS;
        if (p < 96) return FN_WR_REGS;
        return ($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom_range(7, 31));
    endfunction

    function automatic logic [15:0] pick_quantity(input logic [4:0] fn);
        int p;
        p = $urandom_range(0, 99);
        if (p < 4)
            return 16'($urandom);
        case (fn)
            FN_RD_COIL, FN_RD_DISC:
                return (p < 10) ? 16'd512 : (p < 14) ? 16'd513 : 16'($urandom_range(0, 40));
            FN_RD_HOLD, FN_RD_INP:
                return (p < 10) ? 16'd64 : (p < 14) ? 16'd65 : 16'($urandom_range(0, 10));
            FN_WR_COILS:
                return (p < 6) ? 16'd0 : (p < 8) ? 16'd1968 : 16'($urandom_range(1, 24));
            FN_WR_REGS:
                return (p < 6) ? 16'd124 : (p < 8) ? 16'd123 : 16'($urandom_range(1, 6));
            default:
                return 16'($urandom);
        endcase
    endfunction

    // One transaction: start, payload if any, then a response that is usually good.
    task automatic run_transaction();
        request_t r;
        request_t s;
        logic [7:0] resp [0:255];
        logic [15:0] c;
        int rlen;
        int npay;
        int cut;
        int q;
        logic [7:0] b4;
        logic [7:0] b5;
        r = noise_request();
        r.cmd = CMD_START;
        r.fn = pick_function();
        r.qty = pick_quantity(r.fn);
        q = int'(r.qty);
        send_plain(r);
        if (eng_phase == PH_IDLE)
            return;
        // an unknown function leaves the engine as it was: no frame to answer
        if (r.fn == 5'd0 || (r.fn > FN_WR_REG && r.fn != FN_WR_COILS
                             && r.fn != FN_WR_REGS))
            return;
        if (r.fn == FN_WR_COILS || r.fn == FN_WR_REGS)
        begin
            npay = (r.fn == FN_WR_COILS) ? (q + 7) / 8 : q;
            cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, npay - 1)) : npay;
            for (int i = 0; i < cut; i++)
            begin
                s = noise_request();
                s.cmd = CMD_PAY;
                send_plain(s);
            end
            if (cut < npay)
            begin
                if ($urandom_range(0, 1) != 0)
                begin
                    s = noise_request();
                    s.cmd = CMD_TOUT;
                    send_plain(s);
                end
                return;
            end
        end
        if (r.fn <= FN_RD_INP)
        begin
            rlen = (r.fn <= FN_RD_DISC) ? (q + 7) / 8 + 5 : 2 * q + 5;
            b4 = 8'($urandom);
            b5 = 8'($urandom);
        end
        else
        begin
            rlen = 8;
            b4 = echo_word[15:8];
            b5 = echo_word[7:0];
        end
        for (int i = 0; i < 256; i++)
            resp[i] = 8'($urandom);
        resp[0] = ($urandom_range(0, 11) == 0) ? ~r.slave : r.slave;
        resp[1] = {3'b000, r.fn};
        if (r.fn <= FN_RD_INP)
        begin
            resp[2] = ($urandom_range(0, 11) == 0) ? 8'($urandom) : 8'(rlen - 5);
        end
        else
        begin
            resp[2] = r.addr[15:8];
            resp[3] = r.addr[7:0];
            resp[4] = b4;
            resp[5] = ($urandom_range(0, 11) == 0) ? ~b5 : b5;
        end
        c = 16'hFFFF;
        for (int i = 0; i < rlen - 2; i++)
            c = frame_crc_step(c, resp[i]);
        if ($urandom_range(0, 11) == 0)
            c = c ^ (16'h1 << $urandom_range(0, 15));
        resp[rlen-2] = c[7:0];
        resp[rlen-1] = c[15:8];
        cut = ($urandom_range(0, 14) == 0) ? int'($urandom_range(0, rlen - 1)) : rlen;
        for (int i = 0; i < cut; i++)
        begin
            s = noise_request();
            s.cmd = CMD_RXB;
            s.rxb = resp[i];
            send_plain(s);
        end
        if (cut < rlen || $urandom_range(0, 7) == 0)
        begin
            s = noise_request();
            s.cmd = CMD_TOUT;
            send_plain(s);
        end
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result kind %0d", result_kind));
            end
            else
            begin
                e = expected_results.pop_front();
                if (result_kind !== e.kind)
                    note_mismatch($sformatf("kind %0d, want %0d", result_kind, e.kind));
                if (tx_byte !== e.txb)
                    note_mismatch($sformatf("tx_byte %h, want %h", tx_byte, e.txb));
                if (last !== e.lst)
                    note_mismatch($sformatf("last %0d, want %0d", last, e.lst));
                if (status !== e.st)
                    note_mismatch($sformatf("status %0d, want %0d", status, e.st));
                if (read_data !== e.data)
                    note_mismatch($sformatf("read_data %h, want %h", read_data, e.data));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("modbus_rtu_master_engine_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        request_t s;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        command <= CMD_START;
        function_code <= 5'd0;
        slave_address <= 8'h0;
        start_address <= 16'h0;
        quantity <= 16'h0;
        write_value <= 16'h0;
        rx_byte <= 8'h0;
        store_select <= 2'd0;
        store_index <= 6'd0;
        sent_count = 0;
        send_idle_pct = 25;
        recv_stall_pct = 71;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            coil_mem[i] = 8'h0;
            disc_mem[i] = 8'h0;
            hold_mem[i] = 16'h0;
            inp_mem[i] = 16'h0;
        end
        cur_slave = 8'h0;
        cur_func = 8'h0;
        cur_qty = 16'h0;
        resp_len = 16'h0;
        byte_cnt = 16'h0;
        crc_run = 16'hFFFF;
        echo_word = 16'h0;
        eng_phase = PH_IDLE;
        fill_dir_table();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_request(dir_table[i].req, dir_table[i].typed, dir_table[i].want);

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            // swap idling profiles at each third, letting the engine drain first
            if (sent_count >= RANDOM_ITEMS / 3 && send_idle_pct == 25)
            begin
                in_valid <= 1'b0;
                wait_drained();
                send_idle_pct = 71;
                recv_stall_pct = 25;
            end
            else if (sent_count >= 2 * RANDOM_ITEMS / 3 && send_idle_pct == 71)
            begin
                in_valid <= 1'b0;
                wait_drained();
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                run_transaction();
            end
            else
            begin
                s = noise_request();
                if ($urandom_range(0, 1) != 0)
                    s.cmd = CMD_READ;
                send_plain(s);
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("modbus_rtu_master_engine_test: done, clean");
        else
            $display("modbus_rtu_master_engine_test: done, errors");
        $finish;
    end
endmodule

`default_nettype wire
